// ===== sv/joystick_differential_drive_mix_top_macros.svh =====
// Assertion macros for the joystick drive mixer.
// Used by the top level; expects clk and arst_n in the enclosing scope.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIX_TOP_MACROS_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIX_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define JDDM_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define JDDM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/jddm_pkg.sv =====
// Shared constants, types and CORDIC helpers for the joystick drive mixer.
// No dependencies; used by the interfaces, jddm_cordic and the top level.
package jddm_pkg;

	localparam int INPUT_LIMIT = 100;
	localparam int PWM_LIMIT   = 255;

	localparam int AXIS_W = 8;
	localparam int PWM_W  = 9;
	localparam int MAG_W  = $clog2(INPUT_LIMIT + 1);

	// Angle is 4*theta/pi in Q16
	localparam int ANG_FRAC        = 16;
	localparam int ANG_ONE         = 1 << ANG_FRAC;
	localparam int CORDIC_STEPS    = 18;
	localparam int STEPS_PER_STAGE = 2;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int CW              = 26;
	localparam int ZW              = 20;
	localparam int ZQ_W            = ANG_FRAC + 2;
	localparam int CMAG_W          = ANG_FRAC + 1;
	localparam int PROD_W          = CMAG_W + MAG_W;

	// Hundredths rounding and the divide by 100 that truncates it
	localparam int HUND       = 100;
	localparam int RND_W      = PROD_W + $clog2(HUND) + 1;
	localparam int U_W        = $clog2(INPUT_LIMIT * HUND + 1);
	localparam int HUND_SHIFT = 20;
	localparam int HUND_RECIP = (2 ** HUND_SHIFT + HUND - 1) / HUND;
	localparam int HQ_W       = U_W + $clog2(HUND_RECIP + 1);

	// PWM map: (v + IL) * 2PL / 2IL, floor, by reciprocal multiply
	localparam int MAP_NUM   = 2 * PWM_LIMIT;
	localparam int MAP_DEN   = 2 * INPUT_LIMIT;
	localparam int MAP_W     = $clog2(MAP_DEN * MAP_NUM + 1);
	localparam int MAP_SHIFT = 25;
	localparam int MAP_RECIP = (2 ** MAP_SHIFT + MAP_DEN - 1) / MAP_DEN;
	localparam int RECIP_W   = $clog2(MAP_RECIP + 1);
	localparam int MQ_W      = MAP_W + RECIP_W;
	localparam int Q_W       = $clog2(MAP_NUM + 1);

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic signed [PWM_W-1:0]  pwm_t;
	typedef logic [MAG_W-1:0]         mag_t;
	typedef logic signed [CW-1:0]     cw_t;
	typedef logic signed [ZW-1:0]     zw_t;
	typedef logic [ZQ_W-1:0]          zq_t;

	typedef struct packed {
		mag_t d;
		mag_t mov;
		logic same_q;
		logic y_neg;
		logic special;
		zq_t  z_special;
	} side_t;

	typedef struct packed {
		cw_t   cx;
		cw_t   cy;
		zw_t   z;
		side_t side;
	} cordic_t;

	typedef struct packed {
		mag_t mov;
		logic same_q;
		logic y_neg;
		logic t_neg;
	} ctl_t;

	// atan(2^-i) * (4/pi) * 2^16, rounded
	function automatic zw_t atan_entry(input int i);
		case (i)
			0:  return zw_t'(65536);
			1:  return zw_t'(38688);
			2:  return zw_t'(20442);
			3:  return zw_t'(10377);
			4:  return zw_t'(5208);
			5:  return zw_t'(2607);
			6:  return zw_t'(1304);
			7:  return zw_t'(652);
			8:  return zw_t'(326);
			9:  return zw_t'(163);
			10: return zw_t'(81);
			11: return zw_t'(41);
			12: return zw_t'(20);
			13: return zw_t'(10);
			14: return zw_t'(5);
			15: return zw_t'(3);
			16: return zw_t'(1);
			17: return zw_t'(1);
			default: return '0;
		endcase
	endfunction

	// Shift the magnitude, truncating toward zero, and restore the sign
	function automatic cw_t shr_tz(input cw_t v, input int s);
		logic [CW-1:0] m;
		m = v[CW-1] ? (-v) : v;
		m = m >> s;
		return v[CW-1] ? cw_t'(-m) : cw_t'(m);
	endfunction

	function automatic cordic_t cordic_step(input cordic_t a, input int i);
		cordic_t r;
		cw_t     sx;
		cw_t     sy;
		r  = a;
		sx = shr_tz(a.cx, i);
		sy = shr_tz(a.cy, i);
		if (a.cy > 0) begin
			r.cx = a.cx + sy;
			r.cy = a.cy - sx;
			r.z  = a.z + atan_entry(i);
		end else begin
			r.cx = a.cx - sy;
			r.cy = a.cy + sx;
			r.z  = a.z - atan_entry(i);
		end
		return r;
	endfunction

endpackage

// ===== sv/jddm_in_if.sv =====
// Joystick input channel: valid/ready handshake with both axis deflections.
// Depends on jddm_pkg.
interface jddm_in_if;
	import jddm_pkg::*;

	logic  valid;
	logic  ready;
	axis_t x_axis;
	axis_t y_axis;

	modport source (output valid, output x_axis, output y_axis, input ready);
	modport sink   (input valid, input x_axis, input y_axis, output ready);
endinterface

// ===== sv/jddm_out_if.sv =====
// Motor drive output channel: valid/ready handshake with left and right PWM.
// Depends on jddm_pkg.
interface jddm_out_if;
	import jddm_pkg::*;

	logic valid;
	logic ready;
	pwm_t left_pwm;
	pwm_t right_pwm;

	modport source (output valid, output left_pwm, output right_pwm, input ready);
	modport sink   (input valid, input left_pwm, input right_pwm, output ready);
endinterface

// ===== sv/joystick_differential_drive_mix_top.sv =====
// Joystick tank-drive mixer: turns a joystick position (x_axis, y_axis),
// each saturated to +/-100, into signed left and right motor drive values
// in -255..255. The turn share follows the joystick angle: a pipelined
// 18-step CORDIC finds 4*atan2(|y|,|x|)/pi in Q16, which scales the axis
// difference; the result is rounded to hundredths, truncated and mapped
// onto the PWM range with floor division. The block is a 16-stage
// pipeline (one input stage, nine CORDIC stages of two rotations each,
// six stages of scaling and mapping) and takes one transfer every cycle
// while the output is not stalled. A stall on the output holds every
// occupied stage with no empty stage after it, while occupied stages
// behind an empty stage move up to fill it. Depends on jddm_pkg,
// jddm_in_if, jddm_out_if and jddm_cordic.
`include "joystick_differential_drive_mix_top_macros.svh"

module joystick_differential_drive_mix_top (
	input logic        clk,
	input logic        arst_n,
	jddm_in_if.sink    joy,
	jddm_out_if.source pwm
);
	import jddm_pkg::*;

	localparam axis_t AXIS_HI = axis_t'(INPUT_LIMIT);
	localparam axis_t AXIS_LO = axis_t'(-INPUT_LIMIT);

	function automatic axis_t sat_axis(input axis_t v);
		if (v > AXIS_HI) begin
			return AXIS_HI;
		end
		if (v < AXIS_LO) begin
			return AXIS_LO;
		end
		return v;
	endfunction

	// (v + IL) * 2PL, the dividend of the map
	function automatic logic [MAP_W-1:0] map_num(input axis_t v);
		return MAP_W'(v + INPUT_LIMIT) * MAP_W'(MAP_NUM);
	endfunction

	// Floor divide by 2IL through the reciprocal, then recenter on zero
	function automatic pwm_t map_out(input logic [MAP_W-1:0] w);
		logic [MQ_W-1:0] mq;
		logic [Q_W-1:0]  q;
		mq = MQ_W'(w) * MQ_W'(MAP_RECIP);
		q  = mq[MAP_SHIFT +: Q_W];
		return PWM_W'(signed'({1'b0, q}) - PWM_LIMIT);
	endfunction

	// ---------------------------------------------------------------
	// Stage 1: saturate, take magnitudes, pick the quadrant and seed
	// the CORDIC. Axis-aligned and diagonal inputs get an exact angle
	// that bypasses the rotation result later.
	// ---------------------------------------------------------------
	axis_t   x_sat;
	axis_t   y_sat;
	mag_t    ax;
	mag_t    ay;
	cordic_t seed;
	logic    vld_s1;
	logic    adv_s1;
	cordic_t data_s1;

	always_comb begin
		x_sat = sat_axis(joy.x_axis);
		y_sat = sat_axis(joy.y_axis);
		ax    = mag_t'(x_sat[AXIS_W-1] ? -x_sat : x_sat);
		ay    = mag_t'(y_sat[AXIS_W-1] ? -y_sat : y_sat);

		seed.cx             = cw_t'(ax) <<< ANG_FRAC;
		seed.cy             = cw_t'(ay) <<< ANG_FRAC;
		seed.z              = '0;
		seed.side.d         = (ay > ax) ? (ay - ax) : (ax - ay);
		seed.side.mov       = (ax > ay) ? ax : ay;
		seed.side.same_q    = (x_sat[AXIS_W-1] == y_sat[AXIS_W-1]);
		seed.side.y_neg     = y_sat[AXIS_W-1];
		seed.side.special   = (ay == '0) || (ax == '0) || (ax == ay);
		if (ay == '0) begin
			seed.side.z_special = '0;
		end else if (ax == '0) begin
			seed.side.z_special = zq_t'(2 * ANG_ONE);
		end else begin
			seed.side.z_special = zq_t'(ANG_ONE);
		end
	end

	logic    cord_in_ready;
	logic    cord_out_valid;
	logic    adv_s11;
	cordic_t cord_out;

	assign adv_s1    = !vld_s1 || cord_in_ready;
	assign joy.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= joy.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && joy.valid) begin
			data_s1 <= seed;
		end
	end

	// ---------------------------------------------------------------
	// Stages 2..10: CORDIC vectoring
	// ---------------------------------------------------------------
	jddm_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (cord_in_ready),
		.in_data   (data_s1),
		.out_valid (cord_out_valid),
		.out_ready (adv_s11),
		.out_data  (cord_out)
	);

	// ---------------------------------------------------------------
	// Stage 11: clamp the angle to 0..2, substitute the exact angle for
	// the special cases, and split c = angle - 1 into sign and magnitude.
	// ---------------------------------------------------------------
	zq_t               zc;
	logic              cneg;
	logic              vld_s11;
	logic [CMAG_W-1:0] cmag_s11;
	mag_t              d_s11;
	ctl_t              ctl_s11;
	logic              adv_s12;

	always_comb begin
		if (cord_out.side.special) begin
			zc = cord_out.side.z_special;
		end else if (cord_out.z < 0) begin
			zc = '0;
		end else if (cord_out.z > zw_t'(2 * ANG_ONE)) begin
			zc = zq_t'(2 * ANG_ONE);
		end else begin
			zc = zq_t'(cord_out.z);
		end
		cneg = (zc < zq_t'(ANG_ONE));
	end

	assign adv_s11 = !vld_s11 || adv_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (adv_s11) begin
			vld_s11 <= cord_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s11 && cord_out_valid) begin
			cmag_s11       <= cneg ? CMAG_W'(zq_t'(ANG_ONE) - zc)
			                       : CMAG_W'(zc - zq_t'(ANG_ONE));
			d_s11          <= cord_out.side.d;
			ctl_s11.mov    <= cord_out.side.mov;
			ctl_s11.same_q <= cord_out.side.same_q;
			ctl_s11.y_neg  <= cord_out.side.y_neg;
			ctl_s11.t_neg  <= cneg;
		end
	end

	// ---------------------------------------------------------------
	// Stage 12: |turn| in Q16 = |c| * |ay - ax|
	// ---------------------------------------------------------------
	logic              vld_s12;
	logic [PROD_W-1:0] prod_s12;
	ctl_t              ctl_s12;
	logic              adv_s13;

	assign adv_s12 = !vld_s12 || adv_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (adv_s12) begin
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s12 && vld_s11) begin
			prod_s12 <= PROD_W'(cmag_s11) * PROD_W'(d_s11);
			ctl_s12  <= ctl_s11;
		end
	end

	// ---------------------------------------------------------------
	// Stage 13: round to hundredths, half away from zero
	// ---------------------------------------------------------------
	logic [RND_W-1:0] rnd;
	logic             vld_s13;
	logic [U_W-1:0]   u_s13;
	ctl_t             ctl_s13;
	logic             adv_s14;

	assign rnd     = RND_W'(prod_s12) * RND_W'(HUND) + RND_W'(1 << (ANG_FRAC - 1));
	assign adv_s13 = !vld_s13 || adv_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s13 <= 1'b0;
		end else if (adv_s13) begin
			vld_s13 <= vld_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s13 && vld_s12) begin
			u_s13   <= rnd[ANG_FRAC +: U_W];
			ctl_s13 <= ctl_s12;
		end
	end

	// ---------------------------------------------------------------
	// Stage 14: truncate hundredths to whole units (divide by 100 with
	// a reciprocal that is exact over the whole range of u)
	// ---------------------------------------------------------------
	logic [HQ_W-1:0] hq;
	logic            vld_s14;
	mag_t            turn_s14;
	ctl_t            ctl_s14;
	logic            adv_s15;

	assign hq      = HQ_W'(u_s13) * HQ_W'(HUND_RECIP);
	assign adv_s14 = !vld_s14 || adv_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s14 <= 1'b0;
		end else if (adv_s14) begin
			vld_s14 <= vld_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s14 && vld_s13) begin
			turn_s14 <= hq[HUND_SHIFT +: MAG_W];
			ctl_s14  <= ctl_s13;
		end
	end

	// ---------------------------------------------------------------
	// Stage 15: restore the turn sign, route mov and turn to the sides
	// by quadrant, flip both for reverse, and form the map dividend.
	// ---------------------------------------------------------------
	axis_t            turn_sgn;
	axis_t            mov_sgn;
	axis_t            l_val;
	axis_t            r_val;
	logic             vld_s15;
	logic [MAP_W-1:0] wl_s15;
	logic [MAP_W-1:0] wr_s15;
	logic             adv_s16;

	always_comb begin
		turn_sgn = ctl_s14.t_neg ? -axis_t'(turn_s14) : axis_t'(turn_s14);
		mov_sgn  = axis_t'(ctl_s14.mov);
		l_val    = ctl_s14.same_q ? mov_sgn : turn_sgn;
		r_val    = ctl_s14.same_q ? turn_sgn : mov_sgn;
		if (ctl_s14.y_neg) begin
			l_val = -l_val;
			r_val = -r_val;
		end
	end

	assign adv_s15 = !vld_s15 || adv_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s15 <= 1'b0;
		end else if (adv_s15) begin
			vld_s15 <= vld_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s15 && vld_s14) begin
			wl_s15 <= map_num(l_val);
			wr_s15 <= map_num(r_val);
		end
	end

	// ---------------------------------------------------------------
	// Stage 16: output register. Hold while the sink stalls.
	// ---------------------------------------------------------------
	logic vld_s16;
	pwm_t left_s16;
	pwm_t right_s16;

	assign adv_s16 = !vld_s16 || pwm.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
		end else if (adv_s16) begin
			vld_s16 <= vld_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s16 && vld_s15) begin
			left_s16  <= map_out(wl_s15);
			right_s16 <= map_out(wr_s15);
		end
	end

	assign pwm.valid     = vld_s16;
	assign pwm.left_pwm  = left_s16;
	assign pwm.right_pwm = right_s16;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`JDDM_ASSERT_NEXT(a_in_fills_s1, joy.valid && joy.ready, vld_s1, "input transfer lost at stage 1")
	`JDDM_ASSERT_IMPL(a_stall_means_full, !joy.ready, vld_s1, "input stalled with stage 1 empty")
	`JDDM_ASSERT_IMPL(a_round_bound, vld_s13, u_s13 <= U_W'(INPUT_LIMIT * HUND), "rounded turn out of range")
	`JDDM_ASSERT_IMPL(a_pwm_range, pwm.valid, pwm.left_pwm >= -PWM_LIMIT && pwm.left_pwm <= PWM_LIMIT && pwm.right_pwm >= -PWM_LIMIT && pwm.right_pwm <= PWM_LIMIT, "drive value out of range")

endmodule

// ===== sv/jddm_cordic.sv =====
// Pipelined CORDIC vectoring unit, two micro-rotations per register stage.
// Depends on jddm_pkg; side fields ride along with the vector.
module jddm_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  jddm_pkg::cordic_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output jddm_pkg::cordic_t out_data
);
	import jddm_pkg::*;

	localparam int LAST = CORDIC_STAGES - 1;

	cordic_t                  data_sn  [CORDIC_STAGES];
	cordic_t                  stage_in [CORDIC_STAGES];
	cordic_t                  nxt      [CORDIC_STAGES];
	logic [CORDIC_STAGES-1:0] vld_sn;
	logic [CORDIC_STAGES-1:0] prev_vld;
	logic [CORDIC_STAGES-1:0] adv;

	always_comb begin
		stage_in[0] = in_data;
		for (int s = 1; s < CORDIC_STAGES; s++) begin
			stage_in[s] = data_sn[s-1];
		end
	end

	assign prev_vld = {vld_sn[LAST-1:0], in_valid};

	always_comb begin
		cordic_t tmp;
		for (int s = 0; s < CORDIC_STAGES; s++) begin
			tmp = stage_in[s];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				tmp = cordic_step(tmp, s * STEPS_PER_STAGE + k);
			end
			nxt[s] = tmp;
		end
	end

	// A stage advances when empty or when the stage after it advances
	always_comb begin
		adv[LAST] = !vld_sn[LAST] || out_ready;
		for (int s = LAST - 1; s >= 0; s--) begin
			adv[s] = !vld_sn[s] || adv[s+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			for (int s = 0; s < CORDIC_STAGES; s++) begin
				if (adv[s]) begin
					vld_sn[s] <= prev_vld[s];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < CORDIC_STAGES; s++) begin
			if (adv[s] && prev_vld[s]) begin
				data_sn[s] <= nxt[s];
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_sn[LAST];
	assign out_data  = data_sn[LAST];

endmodule
